[sv/swq_pkg.sv]
// Package for the skin weight quantizer: payload structs, constants,
// controller/datapath command and status types. No dependencies.
package swq_pkg;

   localparam int MaxInfluencesIn  = 16;
   localparam int MaxInfluencesOut = 8;
   localparam int MapDepth         = 256;
   localparam logic [3:0] InflOutReset = 4'd4;
   localparam logic [7:0] WeightFull   = 8'hff;

   localparam logic CmdMapWrite = 1'b0;
   localparam logic CmdInfl     = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  mesh_bone;
      logic        bone_invalid;
      logic [15:0] weight;
      logic [7:0]  map_shader_index;
      logic        last_influence;
   } req_type;

   typedef struct packed {
      logic [7:0] shader_bone;
      logic [7:0] quant_weight;
      logic       index_error;
      logic       last_out;
   } rsp_type;

   typedef struct packed {
      logic take_item;    // register accepted item
      logic sel_clear;    // start selection
      logic sel_scan;     // examine one buffer slot
      logic sel_pick;     // latch winner into output slot
      logic div_start;    // start divider on current slot
      logic div_step;     // one division step
      logic emit_load;    // advance to next output slot
      logic vert_done;    // clear influence count
   } cmd_type;

   typedef struct packed {
      logic is_map;
      logic is_last;
      logic scan_end;     // scanned all slots
      logic pick_end;     // all output slots picked
      logic div_end;      // last division step
      logic emit_end;     // last output slot
   } status_type;

endpackage

[sv/swq_datapath.sv]
// Datapath: bone map memory, influence buffer, serial selection,
// restoring divider and combinational result output. Uses swq_pkg.
module swq_datapath #(
   parameter int MAX_IN  = swq_pkg::MaxInfluencesIn,
   parameter int MAX_OUT = swq_pkg::MaxInfluencesOut,
   parameter int DEPTH   = swq_pkg::MapDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  swq_pkg::req_type    req_data,
   input  logic [3:0]          n_out,
   input  swq_pkg::cmd_type    cmd,
   output swq_pkg::status_type stat,
   output swq_pkg::rsp_type    rsp_next
);
   localparam int IW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
   localparam int CW = $clog2(MAX_IN + 1);
   localparam int OW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
   localparam int NW = $clog2(MAX_OUT + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = 16 + NW;   // sum width
   localparam int QW = 9;         // quotient bits (< 512)
   localparam int DW = SW + 1 + QW;

   swq_pkg::req_type item_ff;
   logic [7:0]  map_mem [DEPTH];
   logic [7:0]  map_rd_ff;
   logic [7:0]  buf_bone [MAX_IN];
   logic        buf_inv  [MAX_IN];
   logic [15:0] buf_w    [MAX_IN];
   logic [MAX_IN-1:0] used_ff, used_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] scan_ff;
   logic          have_ff;
   logic [IW-1:0] best_ff;
   logic [NW-1:0] n_eff;
   logic [7:0]  sel_bone [MAX_OUT];
   logic        sel_inv  [MAX_OUT];
   logic [15:0] sel_w    [MAX_OUT];
   logic [OW-1:0] pick_ff, emit_ff;
   logic [SW-1:0] total_ff;
   logic [DW-1:0] rem_ff;       // partial remainder / numerator
   logic [QW-1:0] quo_ff;
   logic [3:0]    step_ff;
   logic [7:0]    budget_ff;
   logic [SW+1:0] den;
   logic [SW+1:0] trial;
   logic [QW-1:0] qclamp;
   logic [7:0]    q8;
   logic [CW-1:0] scan_lim;

   always_comb begin
      if (n_out == 4'd0) n_eff = NW'(1);
      else if ({28'd0, n_out} > MAX_OUT) n_eff = NW'(MAX_OUT);
      else n_eff = NW'(n_out);
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) item_ff <= req_data;
      if (cmd.take_item && req_data.cmd == swq_pkg::CmdMapWrite &&
          {24'd0, req_data.mesh_bone} < DEPTH)
         map_mem[req_data.mesh_bone[AW-1:0]] <= req_data.map_shader_index;
      if (cmd.take_item && req_data.cmd == swq_pkg::CmdInfl && count_ff < CW'(MAX_IN)) begin
         buf_bone[count_ff[IW-1:0]] <= req_data.mesh_bone;
         buf_inv[count_ff[IW-1:0]]  <= req_data.bone_invalid;
         buf_w[count_ff[IW-1:0]]    <= req_data.weight;
      end
      map_rd_ff <= map_mem[sel_bone[emit_ff][AW-1:0]];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.vert_done) count_in = '0;
      else if (cmd.take_item && req_data.cmd == swq_pkg::CmdInfl &&
               count_ff < CW'(MAX_IN)) count_in = count_ff + CW'(1);
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.sel_clear) used_in = '0;
      else if (cmd.sel_pick && have_ff) used_in[best_ff] = 1'b1;
   end

   assign scan_lim = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   // selection: one slot per cycle, strict greater keeps earliest
   always_ff @(posedge clock) begin
      if (cmd.sel_clear) begin
         pick_ff  <= '0;
         total_ff <= '0;
      end
      if (cmd.sel_clear || cmd.sel_pick) begin
         scan_ff <= '0;
         have_ff <= 1'b0;
      end else if (cmd.sel_scan) begin
         if ({1'b0, scan_ff} < {1'b0, scan_lim[IW-1:0]} || scan_lim == CW'(MAX_IN)) begin
            if (!used_ff[scan_ff] && (!have_ff || buf_w[scan_ff] > buf_w[best_ff])) begin
               best_ff <= scan_ff;
               have_ff <= 1'b1;
            end
         end
         scan_ff <= scan_ff + IW'(1);
      end
      if (cmd.sel_pick) begin
         if (have_ff) begin
            sel_bone[pick_ff] <= buf_bone[best_ff];
            sel_inv[pick_ff]  <= buf_inv[best_ff];
            sel_w[pick_ff]    <= buf_w[best_ff];
            total_ff <= total_ff + SW'(buf_w[best_ff]);
         end else begin
            sel_bone[pick_ff] <= '0;
            sel_inv[pick_ff]  <= 1'b1;
            sel_w[pick_ff]    <= '0;
         end
         pick_ff <= pick_ff + OW'(1);
      end
   end

   // restoring division: (2*w*255 + S) / (2*S), one quotient bit per step
   assign den   = {total_ff, 1'b0};
   assign trial = rem_ff[DW-1 -: SW+2] - den;

   always_ff @(posedge clock) begin
      if (cmd.sel_clear) begin
         emit_ff   <= '0;
         budget_ff <= swq_pkg::WeightFull;
      end
      if (cmd.div_start) begin
         rem_ff  <= DW'({sel_w[emit_ff], 9'd0} - {8'd0, sel_w[emit_ff], 1'b0}) + DW'(total_ff);
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff[DW-1 -: SW+2] >= den)
            rem_ff <= {trial[SW:0], rem_ff[QW-2:0], 1'b0};
         else
            rem_ff <= {rem_ff[DW-2:0], 1'b0};
         quo_ff  <= {quo_ff[QW-2:0], rem_ff[DW-1 -: SW+2] >= den};
         step_ff <= step_ff + 4'd1;
      end
      if (cmd.emit_load) begin
         if (!sel_inv[emit_ff]) budget_ff <= budget_ff - q8;
         emit_ff <= emit_ff + OW'(1);
      end
   end

   // numerator top bits start at zero: div_start places the numerator in the low bits of rem_ff
   assign qclamp = (quo_ff > {1'b0, budget_ff}) ? {1'b0, budget_ff} : quo_ff;
   assign q8 = (total_ff == '0) ? 8'd0 : qclamp[7:0];

   always_comb begin
      rsp_next = '0;
      rsp_next.last_out = ({{(NW-OW){1'b0}}, emit_ff} + NW'(1)) == n_eff;
      if (!sel_inv[emit_ff]) begin
         rsp_next.quant_weight = q8;
         if ({24'd0, sel_bone[emit_ff]} >= DEPTH) begin
            rsp_next.shader_bone = 8'hff;
            rsp_next.index_error = 1'b1;
         end else begin
            rsp_next.shader_bone = map_rd_ff;
            rsp_next.index_error = map_rd_ff == 8'hff;
         end
      end
   end

   assign stat.is_map   = item_ff.cmd == swq_pkg::CmdMapWrite;
   assign stat.is_last  = item_ff.last_influence;
   assign stat.scan_end = scan_ff == IW'(MAX_IN - 1);
   assign stat.pick_end = ({{(NW-OW){1'b0}}, pick_ff} + NW'(1)) == n_eff;
   assign stat.div_end  = step_ff == 4'(QW - 1);
   assign stat.emit_end = rsp_next.last_out;

endmodule

[sv/swq_control.sv]
// Controller state machine: sequences capture, selection, division
// and result handoff. Uses swq_pkg.
module swq_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  swq_pkg::status_type stat,
   output swq_pkg::cmd_type    cmd
);
   typedef enum logic [6:0] {
      IDLE  = 7'b0000001,
      DECO  = 7'b0000010,
      SCAN  = 7'b0000100,
      PICK  = 7'b0001000,
      DIVS  = 7'b0010000,
      LOAD  = 7'b0100000,
      SEND  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == IDLE;
   assign rsp_valid = state_ff == SEND;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in = DECO;
            end
         end
         DECO: begin
            if (stat.is_map || !stat.is_last) state_in = IDLE;
            else begin
               cmd.sel_clear = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.sel_scan = 1'b1;
            if (stat.scan_end) state_in = PICK;
         end
         PICK: begin
            cmd.sel_pick = 1'b1;
            if (stat.pick_end) state_in = LOAD;
            else state_in = SCAN;
         end
         LOAD: begin
            cmd.div_start = 1'b1;
            state_in = DIVS;
         end
         DIVS: begin
            cmd.div_step = 1'b1;
            if (stat.div_end) state_in = SEND;
         end
         SEND: begin
            if (rsp_ready) begin
               cmd.emit_load = 1'b1;
               if (stat.emit_end) begin
                  cmd.vert_done = 1'b1;
                  state_in = IDLE;
               end else state_in = LOAD;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |=> state_ff == DECO)
      else $error("capture not followed by decode");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      cmd.vert_done |=> req_ready)
      else $error("not idle after vertex");

endmodule

[sv/skin_weight_quantizer.sv]
// Skin weight quantizer top level: controller plus datapath.
// A map write or non-final influence is captured and decoded. A final
// influence is decoded, each output slot is filled by a scan of all buffer
// slots and a pick; each result is divided by restoring division and sent
// on rsp_ready. Synchronous active-high reset clears count, selection flags
// and FSM, sets nout_ff to InflOutReset; map, buffer undefined until written.
module skin_weight_quantizer #(
   parameter int MAX_IN  = swq_pkg::MaxInfluencesIn,
   parameter int MAX_OUT = swq_pkg::MaxInfluencesOut,
   parameter int DEPTH   = swq_pkg::MapDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  swq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output swq_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [3:0]       csr_wdata
);
   swq_pkg::cmd_type    cmd;
   swq_pkg::status_type stat;
   logic [3:0]          nout_ff;

   always_ff @(posedge clock) begin
      if (reset) nout_ff <= swq_pkg::InflOutReset;
      else if (csr_we) nout_ff <= csr_wdata;
   end

   swq_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   swq_datapath #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT), .DEPTH(DEPTH)) u_dp (
      .clock, .reset, .req_data, .n_out(nout_ff), .cmd, .stat,
      .rsp_next(rsp_data)
   );

endmodule
